[design/lzss_pkg.sv]
// lzss_pkg: shared constants for the lzss ring decompressor
// configuration register codes, reset values and format constants
// no dependencies
package lzss_pkg;

  // ring dictionary depth, default for the top-level parameter
  localparam int unsigned DICT_DEPTH_DEF = 4096;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DICT_START    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LENGTH = 2'd1;

  // configuration reset values
  localparam logic [11:0] DICT_START_RST    = 12'hFEE;
  localparam logic [31:0] OUTPUT_LENGTH_RST = 32'd0;

  // reference format: length field plus minimum match
  localparam logic [4:0] MIN_MATCH = 5'd3;
  // guard bit placed above the eight flags
  localparam logic [8:0] FLAG_GUARD = 9'h100;

endpackage

[design/lzss_ring_decompressor.sv]
// lzss_ring_decompressor: byte-wise lzss decoder with a ring dictionary
// flag and offset-low bytes are taken without output; a literal passes through one emit state
// and a reference through a first read, then one emit per copied byte, over a single ring
// read/write port pair; a reference of 3..18 bytes holds the input, and stalls on out add to it
// reset: control state and configuration return to defaults; the ring is not swept,
// a fill count since stream start makes unwritten entries read as zero
module lzss_ring_decompressor
  import lzss_pkg::*;
#(
  parameter int unsigned DICT_DEPTH = DICT_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // compressed input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_byte,
  input  logic                 in_first_of_stream,
  // decoded output
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 out_last_of_run,
  output logic                 out_stream_done,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int unsigned AW = $clog2(DICT_DEPTH);
  localparam int unsigned FW = AW + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LIT_EM,
    ST_COPY_RD,
    ST_COPY_EM
  } state_t;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_LIT,
    PH_LO,
    PH_HI
  } phase_t;

  // control registers
  state_t          state_r, state_nxt;
  phase_t          phase_r, phase_nxt;
  logic [8:0]      flags_r, flags_nxt;
  logic [7:0]      latch_r, latch_nxt;
  logic [31:0]     rem_r, rem_nxt;
  logic [AW-1:0]   wp_r, wp_nxt;
  logic [AW-1:0]   base_r, base_nxt;
  logic [FW-1:0]   fill_r, fill_nxt;
  logic [AW-1:0]   src_r, src_nxt;
  logic [4:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]   cfg_start_r;
  logic [31:0]     cfg_len_r;
  logic            out_valid_r, out_valid_nxt;

  // payload registers
  logic [7:0]      byte_r, byte_nxt;
  logic [7:0]      out_byte_r, out_byte_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_done_r, out_done_nxt;

  // ring memory and its read side
  logic [7:0]      ring_mem [DICT_DEPTH];
  logic [7:0]      mem_q_r;
  logic            hit_r;
  logic            fwd_r;
  logic [7:0]      fwd_data_r;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [7:0]      wr_data;
  logic [7:0]      ring_val;
  logic [AW-1:0]   rd_offset;

  // decode helpers
  logic            in_acc;
  logic            slot_free;
  logic [31:0]     eff_rem;
  phase_t          eff_phase;
  logic [8:0]      eff_flags;
  logic [7:0]      eff_latch;
  logic [8:0]      flags_shifted;
  phase_t          phase_after;
  logic            emit_last;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;
  assign out_stream_done = out_done_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_start_r <= AW'(DICT_START_RST);
      cfg_len_r   <= OUTPUT_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DICT_START:    cfg_start_r <= cfg_data[AW-1:0];
        REG_OUTPUT_LENGTH: cfg_len_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // stream-start view of the parse state
  assign eff_rem   = in_first_of_stream ? cfg_len_r : rem_r;
  assign eff_phase = in_first_of_stream ? PH_FLAG : phase_r;
  assign eff_flags = in_first_of_stream ? 9'd0 : flags_r;
  assign eff_latch = in_first_of_stream ? 8'd0 : latch_r;

  // advance to the next flag once an item completes
  assign flags_shifted = {1'b0, flags_r[8:1]};
  assign phase_after   = (flags_shifted <= 9'd1) ? PH_FLAG :
                         (flags_shifted[0] ? PH_LIT : PH_LO);

  // byte read from the ring: forwarded, stored, or zero when never written
  assign ring_val  = fwd_r ? fwd_data_r : (hit_r ? mem_q_r : 8'd0);
  assign emit_last = (cnt_r == 5'd1) || (rem_r == 32'd1);
  assign rd_offset = rd_addr - base_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    flags_nxt     = flags_r;
    latch_nxt     = latch_r;
    rem_nxt       = rem_r;
    wp_nxt        = wp_r;
    base_nxt      = base_r;
    fill_nxt      = fill_r;
    src_nxt       = src_r;
    cnt_nxt       = cnt_r;
    byte_nxt      = byte_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;
    rd_en         = 1'b0;
    rd_addr       = src_r;
    wr_en         = 1'b0;
    wr_data       = ring_val;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          // stream start restores the parse state
          if (in_first_of_stream) begin
            wp_nxt   = cfg_start_r;
            base_nxt = cfg_start_r;
            fill_nxt = '0;
          end
          phase_nxt = eff_phase;
          flags_nxt = eff_flags;
          latch_nxt = eff_latch;
          rem_nxt   = eff_rem;
          if (eff_rem != 32'd0) begin
            case (eff_phase)
              PH_FLAG: begin
                flags_nxt = {1'b0, in_byte} | FLAG_GUARD;
                phase_nxt = in_byte[0] ? PH_LIT : PH_LO;
              end
              PH_LIT: begin
                byte_nxt  = in_byte;
                flags_nxt = flags_shifted;
                phase_nxt = phase_after;
                state_nxt = ST_LIT_EM;
              end
              PH_LO: begin
                latch_nxt = in_byte;
                phase_nxt = PH_HI;
              end
              PH_HI: begin
                src_nxt   = AW'({in_byte[7:4], eff_latch});
                cnt_nxt   = {1'b0, in_byte[3:0]} + MIN_MATCH;
                latch_nxt = 8'd0;
                flags_nxt = flags_shifted;
                phase_nxt = phase_after;
                state_nxt = ST_COPY_RD;
              end
              default: ;
            endcase
          end
        end
      end

      // literal: one write and one result
      ST_LIT_EM: begin
        if (slot_free) begin
          wr_en         = 1'b1;
          wr_data       = byte_r;
          out_valid_nxt = 1'b1;
          out_byte_nxt  = byte_r;
          out_last_nxt  = 1'b1;
          out_done_nxt  = (rem_r == 32'd1);
          rem_nxt       = rem_r - 32'd1;
          wp_nxt        = wp_r + AW'(1);
          fill_nxt      = (fill_r == FW'(DICT_DEPTH)) ? fill_r : fill_r + FW'(1);
          state_nxt     = ST_IDLE;
        end
      end

      // first read of a reference copy
      ST_COPY_RD: begin
        rd_en     = 1'b1;
        rd_addr   = src_r;
        state_nxt = ST_COPY_EM;
      end

      // emit one copied byte and, unless it ends the run, read the next
      ST_COPY_EM: begin
        if (slot_free) begin
          wr_en         = 1'b1;
          wr_data       = ring_val;
          out_valid_nxt = 1'b1;
          out_byte_nxt  = ring_val;
          out_last_nxt  = emit_last;
          out_done_nxt  = (rem_r == 32'd1);
          rem_nxt       = rem_r - 32'd1;
          cnt_nxt       = cnt_r - 5'd1;
          wp_nxt        = wp_r + AW'(1);
          fill_nxt      = (fill_r == FW'(DICT_DEPTH)) ? fill_r : fill_r + FW'(1);
          src_nxt       = src_r + AW'(1);
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = src_r + AW'(1);
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_FLAG;
      flags_r     <= '0;
      latch_r     <= '0;
      rem_r       <= OUTPUT_LENGTH_RST;
      wp_r        <= AW'(DICT_START_RST);
      base_r      <= AW'(DICT_START_RST);
      fill_r      <= '0;
      src_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      flags_r     <= flags_nxt;
      latch_r     <= latch_nxt;
      rem_r       <= rem_nxt;
      wp_r        <= wp_nxt;
      base_r      <= base_nxt;
      fill_r      <= fill_nxt;
      src_r       <= src_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    byte_r     <= byte_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
  end

  // ring write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wp_r] <= wr_data;
    end
  end

  // ring read port with bypass of a same-cycle write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r    <= ring_mem[rd_addr];
      hit_r      <= ({1'b0, rd_offset} < fill_r);
      fwd_r      <= wr_en && (wp_r == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(DICT_DEPTH))
    else $error("ring fill count beyond depth");

  a_emit_has_budget: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LIT_EM || state_r == ST_COPY_EM) |-> rem_r != 32'd0)
    else $error("emit with no bytes remaining");

  a_copy_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COPY_RD || state_r == ST_COPY_EM) |-> cnt_r != 5'd0)
    else $error("copy running with zero count");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stream_done) |-> out_last_of_run)
    else $error("stream done without end of run");

endmodule

[tb/lzss_decode_checker.sv]
// lzss_decode_checker: watches the input, output and config channels of the decoder
// predicts every decoded byte and compares each output request against it
// depends on lzss_pkg for register indexes, reset values and format constants
module lzss_decode_checker
  import lzss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [7:0]           in_byte,
  input  logic                 in_first_of_stream,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [7:0]           out_byte,
  input  logic                 out_last_of_run,
  input  logic                 out_stream_done,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    EXPECT_FLAG,
    EXPECT_LITERAL,
    EXPECT_OFS_LO,
    EXPECT_OFS_HI
  } parse_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
  } decoded_t;

  // shadow configuration
  logic [11:0]  start_reg;
  logic [31:0]  length_reg;

  // shadow decoder state
  logic [7:0]   ring [DICT_DEPTH_DEF];
  logic [11:0]  write_pos;
  logic [8:0]   flags;
  parse_state_t parse;
  logic [7:0]   ofs_lo;
  logic [31:0]  bytes_left;

  decoded_t     expected_bytes [$];

  task automatic clear_ring();
    for (int i = 0; i < DICT_DEPTH_DEF; i++) ring[i] = 8'h00;
  endtask

  // one decoded byte goes into the ring and onto the expected queue
  task automatic put_byte(input logic [7:0] b);
    decoded_t d;
    ring[write_pos] = b;
    write_pos       = write_pos + 12'd1;
    bytes_left      = bytes_left - 32'd1;
    d.data          = b;
    d.last          = 1'b0;
    d.done          = (bytes_left == 32'd0);
    expected_bytes.push_back(d);
  endtask

  // move on to the next flag, or back to a flag byte once the guard is reached
  task automatic advance_flags();
    flags = flags >> 1;
    if (flags <= 9'd1) parse = EXPECT_FLAG;
    else parse = flags[0] ? EXPECT_LITERAL : EXPECT_OFS_LO;
  endtask

  // work out every byte that one accepted input request yields
  task automatic decode_byte(input logic [7:0] b, input logic first);
    int unsigned count;
    int unsigned emitted;
    logic [11:0] src;
    decoded_t    tail;
    emitted = 0;
    if (first) begin
      clear_ring();
      write_pos  = start_reg;
      flags      = '0;
      parse      = EXPECT_FLAG;
      ofs_lo     = '0;
      bytes_left = length_reg;
    end
    if (bytes_left != 32'd0) begin
      case (parse)
        EXPECT_FLAG: begin
          flags = FLAG_GUARD | {1'b0, b};
          parse = flags[0] ? EXPECT_LITERAL : EXPECT_OFS_LO;
        end
        EXPECT_LITERAL: begin
          put_byte(b);
          emitted = 1;
          advance_flags();
        end
        EXPECT_OFS_LO: begin
          ofs_lo = b;
          parse  = EXPECT_OFS_HI;
        end
        default: begin
          src   = {b[7:4], ofs_lo};
          count = 32'(b[3:0]) + 32'(MIN_MATCH);
          // copy one byte at a time so an overlapping source sees fresh bytes
          while (count > 0 && bytes_left != 32'd0) begin
            put_byte(ring[src]);
            src     = src + 12'd1;
            count   = count - 1;
            emitted = emitted + 1;
          end
          ofs_lo = '0;
          advance_flags();
        end
      endcase
    end
    if (emitted > 0) begin
      tail      = expected_bytes.pop_back();
      tail.last = 1'b1;
      expected_bytes.push_back(tail);
    end
  endtask

  // monitor: config, then input, then output at each edge
  always @(posedge clk) begin
    decoded_t want;
    decoded_t got;
    if (!rst_n) begin
      start_reg  = DICT_START_RST;
      length_reg = OUTPUT_LENGTH_RST;
      clear_ring();
      write_pos  = DICT_START_RST;
      flags      = '0;
      parse      = EXPECT_FLAG;
      ofs_lo     = '0;
      bytes_left = OUTPUT_LENGTH_RST;
      expected_bytes.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DICT_START:    start_reg = cfg_data[11:0];
          REG_OUTPUT_LENGTH: length_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) decode_byte(in_byte, in_first_of_stream);
      if (out_valid && !out_stall) begin
        got = '{data: out_byte, last: out_last_of_run, done: out_stream_done};
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected output byte %02h last %b done %b",
                   $time, got.data, got.last, got.done);
          fail_count = fail_count + 1;
        end else begin
          want = expected_bytes.pop_front();
          if (got !== want) begin
            $display("%0t: output mismatch expected byte %02h last %b done %b, actual byte %02h last %b done %b",
                     $time, want.data, want.last, want.done, got.data, got.last, got.done);
            fail_count = fail_count + 1;
          end
        end
      end
    end
    pending <= expected_bytes.size();
  end

endmodule

[tb/tb.sv]
// tb: stimulus and verdict for the lzss ring decompressor
// builds compressed streams, drives config and input requests, idles both sides
// depends on lzss_pkg, lzss_ring_decompressor and lzss_decode_checker
module tb;
  import lzss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;
  localparam int                   IDLE_LIMIT = 4000;
  localparam int                   TAIL_CYCLES = 40;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_byte = '0;
  logic                 in_first_of_stream = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           out_byte;
  logic                 out_last_of_run;
  logic                 out_stream_done;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  int                   fail_count;
  int                   pending;
  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;
  int unsigned          items_sent = 0;
  int                   idle_cycles = 0;
  logic [11:0]          cur_start = DICT_START_RST;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  lzss_ring_decompressor u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_byte            (in_byte),
    .in_first_of_stream (in_first_of_stream),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .out_last_of_run    (out_last_of_run),
    .out_stream_done    (out_stream_done),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  lzss_decode_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_byte            (in_byte),
    .in_first_of_stream (in_first_of_stream),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .out_last_of_run    (out_last_of_run),
    .out_stream_done    (out_stream_done),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog on cycles with no request accepted anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // one compressed byte, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_byte            <= b;
    in_first_of_stream <= first;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent = items_sent + 1;
  endtask

  // stop sending until every expected byte is out and the decoder has settled
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_DICT_START) cur_start = val[11:0];
  endtask

  // well-formed flag groups with random content, a little noise, cut anywhere
  task automatic random_stream(input int unsigned n_items);
    logic [7:0]  flag;
    logic [11:0] wp;
    logic [11:0] src;
    logic [3:0]  len;
    int unsigned sent;
    logic        first;
    first = 1'b1;
    wp    = cur_start;
    sent  = 0;
    while (sent < n_items) begin
      flag = 8'($urandom);
      send_byte(flag, first);
      first = 1'b0;
      sent  = sent + 1;
      for (int i = 0; i < 8 && sent < n_items; i++) begin
        if ($urandom_range(15) == 0) begin
          send_byte(8'($urandom), 1'b0);
          sent = sent + 1;
        end else if (flag[i]) begin
          send_byte(8'($urandom), 1'b0);
          sent = sent + 1;
          wp   = wp + 12'd1;
        end else begin
          len = 4'($urandom);
          // mostly recent history, sometimes anywhere in the ring
          if ($urandom_range(3) == 0) src = 12'($urandom);
          else src = wp - 12'($urandom_range(32, 1));
          send_byte(src[7:0], 1'b0);
          sent = sent + 1;
          if (sent < n_items) begin
            send_byte({src[11:8], len}, 1'b0);
            sent = sent + 1;
          end
          wp = wp + 12'(len) + 12'(MIN_MATCH);
        end
      end
    end
  endtask

  initial begin
    int unsigned phase_start;
    int unsigned pick;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ring wrap at the top position, overlapping copy, copy cut by length
    write_reg(REG_DICT_START, 32'd4095);
    write_reg(REG_OUTPUT_LENGTH, 32'd40);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    send_byte(8'hA5, 1'b0);
    send_byte(8'hFD, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h05, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'h33, 1'b0);
    drain();

    // zero output length: the whole stream is ignored
    write_reg(REG_OUTPUT_LENGTH, 32'd0);
    send_byte(8'h01, 1'b1);
    send_byte(8'h42, 1'b0);
    drain();

    // longest length, bottom position, truncated reference then a restart
    write_reg(REG_DICT_START, 32'd0);
    write_reg(REG_OUTPUT_LENGTH, 32'hFFFF_FFFF);
    send_byte(8'h00, 1'b1);
    send_byte(8'h10, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    drain();

    // random streams under each idling mix
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < 46) begin
        pick = $urandom_range(7);
        if (pick == 0) write_reg(REG_DICT_START, 32'd0);
        else if (pick == 1) write_reg(REG_DICT_START, 32'd4095);
        else write_reg(REG_DICT_START, $urandom_range(4095));
        if ($urandom_range(7) == 0) write_reg(REG_OUTPUT_LENGTH, $urandom_range(4, 1));
        else write_reg(REG_OUTPUT_LENGTH, $urandom_range(160, 16));
        random_stream($urandom_range(40, 6));
        drain();
      end
    end

    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
design/lzss_pkg.sv
design/lzss_ring_decompressor.sv
tb/lzss_decode_checker.sv
tb/tb.sv
